// ===== sv/mjemp_pkg.sv =====
package mjemp_pkg;

    localparam int NUM_JOINTS        = 5;
    localparam int HOME_ANGLE_DEF    = 90;
    localparam int TIME_BITS_DEF     = 32;
    localparam int MAX_ANGLE         = 180;
    localparam int MSPD_W            = 10;
    localparam int CFG_IDX_W         = 3;
    localparam int DUR_W             = 18;   // 8-bit distance times 10-bit rate
    localparam int FRAC_W            = 17;   // quotient can reach 65536 only when elapsed equals dur

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MOVE = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] time_ms;
        logic [2:0]  joint_index;
        logic [7:0]  single_angle;
        logic [7:0]  goal_joint1;
        logic [7:0]  goal_joint2;
        logic [7:0]  goal_joint3;
        logic [7:0]  goal_joint4;
        logic [7:0]  goal_joint5;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pos_joint1;
        logic [7:0] pos_joint2;
        logic [7:0] pos_joint3;
        logic [7:0] pos_joint4;
        logic [7:0] pos_joint5;
        logic [4:0] moving_mask;
    } out_word_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;      // latch input word and apply command
        logic       start;     // begin work on joint at sel
        logic [2:0] sel;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic done;            // joint at sel finished
    } dp_stat_t;

    function automatic logic [7:0] sat_angle(input logic [7:0] v);
        sat_angle = (v > 8'(MAX_ANGLE)) ? 8'(MAX_ANGLE) : v;
    endfunction

endpackage

// ===== sv/mjemp_datapath.sv =====
module mjemp_datapath #(
    parameter int HOME_ANGLE = mjemp_pkg::HOME_ANGLE_DEF,
    parameter int TIME_BITS  = mjemp_pkg::TIME_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mjemp_pkg::in_word_t                  in_word,
    input  logic                                 cfg_we,
    input  logic [mjemp_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [mjemp_pkg::MSPD_W-1:0]         cfg_data,
    input  mjemp_pkg::dp_cmd_t                   cmd,
    output mjemp_pkg::dp_stat_t                  stat,
    output mjemp_pkg::out_word_t                 result
);
    import mjemp_pkg::*;

    typedef enum logic [7:0] {
        J_IDLE = 8'b0000_0001,
        J_MUL  = 8'b0000_0010,
        J_DIV  = 8'b0000_0100,
        J_SQ   = 8'b0000_1000,
        J_CUBE = 8'b0001_0000,
        J_EASE = 8'b0010_0000,
        J_MIX  = 8'b0100_0000,
        J_DONE = 8'b1000_0000
    } jst_t;

    logic [MSPD_W-1:0]    mspd_reg   [NUM_JOINTS];
    logic [7:0]           tgt_reg    [NUM_JOINTS];
    logic [7:0]           st_reg     [NUM_JOINTS];
    logic [7:0]           cur_reg    [NUM_JOINTS];
    logic [TIME_BITS-1:0] stime_reg  [NUM_JOINTS];
    logic [TIME_BITS-1:0] now_reg;

    jst_t                 jst_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [TIME_BITS-1:0] el_reg;
    logic [DUR_W:0]       rem_reg;
    logic [FRAC_W-1:0]    quo_reg;
    logic [4:0]           cnt_reg;
    logic [16:0]          g_reg;
    logic [33:0]          sq_reg;
    logic [50:0]          cube_reg;
    logic                 hi_reg;
    logic [16:0]          e_reg;
    logic [7:0]           res_reg;

    logic [2:0] j;
    logic [7:0] t_a, s_a, dist_abs;
    logic [TIME_BITS-1:0] el_now;
    logic [DUR_W:0] rem_sh;
    logic [DUR_W+1:0] trial;
    logic signed [9:0]  dist_s;
    logic signed [26:0] prod;
    logic [24:0] mix;

    assign j = cmd.sel;
    assign t_a = tgt_reg[j];
    assign s_a = st_reg[j];
    assign dist_abs = (t_a > s_a) ? (t_a - s_a) : (s_a - t_a);
    assign el_now = now_reg - stime_reg[j];
    assign stat.done = (jst_reg == J_DONE) && (res_reg != 8'hFF);

    // Restoring divider: one quotient bit per cycle, 16 steps.
    assign rem_sh = {rem_reg[DUR_W-1:0], 1'b0};
    assign trial  = {1'b0, rem_sh} - {2'b00, dur_reg};
    assign dist_s = $signed({2'b00, t_a}) - $signed({2'b00, s_a});
    assign prod   = dist_s * $signed({1'b0, e_reg});
    assign mix    = 25'($signed({1'b0, s_a, 16'h0000}) + prod);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            jst_reg <= J_IDLE;
            now_reg <= '0;
            for (int i = 0; i < NUM_JOINTS; i++) begin
                mspd_reg[i]  <= MSPD_W'(10);
                tgt_reg[i]   <= 8'(HOME_ANGLE);
                st_reg[i]    <= 8'(HOME_ANGLE);
                cur_reg[i]   <= 8'(HOME_ANGLE);
                stime_reg[i] <= '0;
            end
        end else begin
            if (cfg_we && cfg_idx < CFG_IDX_W'(NUM_JOINTS)) begin
                mspd_reg[cfg_idx] <= cfg_data;
            end
            if (cmd.load) begin
                now_reg <= in_word.time_ms[TIME_BITS-1:0];
                if (in_word.cmd == CMD_MOVE) begin
                    for (int i = 0; i < NUM_JOINTS; i++) begin
                        stime_reg[i] <= in_word.time_ms[TIME_BITS-1:0];
                        st_reg[i]    <= cur_reg[i];
                    end
                    tgt_reg[0] <= sat_angle(in_word.goal_joint1);
                    tgt_reg[1] <= sat_angle(in_word.goal_joint2);
                    tgt_reg[2] <= sat_angle(in_word.goal_joint3);
                    tgt_reg[3] <= sat_angle(in_word.goal_joint4);
                    tgt_reg[4] <= sat_angle(in_word.goal_joint5);
                end else if (in_word.cmd == CMD_SET && in_word.joint_index >= 3'd1
                             && in_word.joint_index <= 3'(NUM_JOINTS)) begin
                    tgt_reg[in_word.joint_index - 3'd1] <= sat_angle(in_word.single_angle);
                    cur_reg[in_word.joint_index - 3'd1] <= sat_angle(in_word.single_angle);
                end
            end
            case (jst_reg)
                J_IDLE: if (cmd.start) begin
                    if (cur_reg[j] == t_a) jst_reg <= J_DONE;
                    else jst_reg <= J_MUL;
                end
                J_MUL: begin
                    dur_reg <= dist_abs * mspd_reg[j];
                    el_reg  <= el_now;
                    jst_reg <= J_DIV;
                    cnt_reg <= '0;
                    quo_reg <= '0;
                end
                J_DIV: begin
                    if (cnt_reg == 5'd0 &&
                        {{TIME_BITS{1'b0}}, dur_reg} <= {{DUR_W{1'b0}}, el_reg}) begin
                        cur_reg[j] <= t_a;
                        jst_reg <= J_DONE;
                    end else if (cnt_reg == 5'd0) begin
                        // Elapsed time is below dur here, so it fits the remainder.
                        rem_reg <= (DUR_W+1)'(el_reg);
                        cnt_reg <= 5'd1;
                    end else begin
                        // Remainder stays below dur, so only 16 numerator bits are shifted in.
                        if (!trial[DUR_W+1]) begin
                            rem_reg <= trial[DUR_W:0];
                            quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
                        end
                        if (cnt_reg == 5'd16) jst_reg <= J_SQ;
                        else cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                J_SQ: begin
                    hi_reg  <= quo_reg >= 17'd32768;
                    g_reg   <= (quo_reg >= 17'd32768) ? 17'd65536 - quo_reg : quo_reg;
                    jst_reg <= J_CUBE;
                end
                J_CUBE: begin
                    sq_reg  <= g_reg * g_reg;
                    jst_reg <= J_EASE;
                end
                J_EASE: begin
                    cube_reg <= sq_reg * g_reg;
                    jst_reg  <= J_MIX;
                end
                J_MIX: begin
                    e_reg <= hi_reg ? 17'd65536 - 17'(cube_reg[50:30])
                                    : 17'(cube_reg[50:30]);
                    jst_reg <= J_DONE;
                    res_reg <= 8'hFF;
                end
                J_DONE: begin
                    if (res_reg == 8'hFF) begin
                        cur_reg[j] <= sat_angle(mix[23:16]);
                        res_reg <= '0;
                    end else begin
                        jst_reg <= J_IDLE;
                    end
                end
                default: jst_reg <= J_IDLE;
            endcase
            if (jst_reg == J_IDLE || jst_reg == J_MUL) res_reg <= '0;
        end
    end

    always_comb begin
        result.pos_joint1 = cur_reg[0];
        result.pos_joint2 = cur_reg[1];
        result.pos_joint3 = cur_reg[2];
        result.pos_joint4 = cur_reg[3];
        result.pos_joint5 = cur_reg[4];
        for (int i = 0; i < NUM_JOINTS; i++) begin
            result.moving_mask[i] = cur_reg[i] != tgt_reg[i];
        end
    end

endmodule

// ===== sv/mjemp_ctrl.sv =====
module mjemp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mjemp_pkg::dp_cmd_t   cmd,
    input  mjemp_pkg::dp_stat_t  stat
);
    import mjemp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GO   = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] sel_reg, sel_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            ov_reg    <= ov_next;
        end
    end

    // A new word may enter while the previous result still waits; it is
    // only held up at the output stage itself.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ov_next    = ov_reg;
        cmd.load   = 1'b0;
        cmd.start  = 1'b0;
        cmd.sel    = sel_reg;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.load   = 1'b1;
                sel_next   = '0;
                state_next = S_GO;
            end
            S_GO: begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: if (stat.done) begin
                if (sel_reg == 3'(NUM_JOINTS - 1)) begin
                    state_next = S_OUT;
                end else begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = S_GO;
                end
            end
            S_OUT: if (!ov_reg || out_ready) begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/multi_joint_eased_motion_profile.sv =====
// Channel | Handshake                  | Payload
// in      | in_valid / in_ready        | in_data   (mjemp_pkg::in_word_t)
// out     | out_valid / out_ready      | out_data  (mjemp_pkg::out_word_t)
// cfg     | cfg_we                     | cfg_index, cfg_data
//
// A word is accepted in the idle state and the five joints are then processed
// in turn through one shared unit. A joint already at its target skips the math,
// one that has run out of time snaps to its target, and an eased joint spends
// most of its time in the 16-step restoring divider. The next word is taken only
// once the result word has been written, which a stalled output can hold up.
// Reset is asynchronous and active low; it homes every joint.
// A result word is held in an output register, so the next input word is
// taken while it still waits; a stalled output only blocks the final write.
module multi_joint_eased_motion_profile #(
    parameter int HOME_ANGLE = mjemp_pkg::HOME_ANGLE_DEF,
    parameter int TIME_BITS  = mjemp_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mjemp_pkg::in_word_t              in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mjemp_pkg::out_word_t             out_data,
    input  logic                             cfg_we,
    input  logic [mjemp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mjemp_pkg::MSPD_W-1:0]     cfg_data
);
    import mjemp_pkg::*;

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_word_t result;
    out_word_t out_reg;
    logic      ov_prev_reg;

    mjemp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mjemp_datapath #(
        .HOME_ANGLE (HOME_ANGLE),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    // Capture the joint state the cycle a fresh result becomes valid, so
    // later work on the next word does not disturb the waiting word.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ov_prev_reg <= 1'b0;
        end else begin
            ov_prev_reg <= out_valid && !out_ready;
        end
    end

    always_ff @(posedge clk) begin
        if (!ov_prev_reg || !out_valid) begin
            out_reg <= result;
        end
    end

    assign out_data = (out_valid && !ov_prev_reg) ? result : out_reg;

endmodule

// ===== verif/multi_joint_eased_motion_profile_tb.sv =====
module multi_joint_eased_motion_profile_tb;

    import mjemp_pkg::*;

    // Clock, reset and the ports of the block under test.
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MSPD_W-1:0]    cfg_data;

    multi_joint_eased_motion_profile dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Shadow copy of the joint state, kept in step with every accepted word.
    logic [9:0]  rate_ms[NUM_JOINTS];
    logic [7:0]  goal_ang[NUM_JOINTS];
    logic [7:0]  origin_ang[NUM_JOINTS];
    logic [31:0] origin_ms[NUM_JOINTS];
    logic [7:0]  now_ang[NUM_JOINTS];

    out_word_t pose_queue[$];
    int        failures;
    int        send_idle_pct;
    int        recv_stall_pct;

    // Joints are numbered from one in the words; array slot is joint minus one.
    function automatic logic [7:0] clamp_deg(input logic [7:0] v);
        return (v > 8'd180) ? 8'd180 : v;
    endfunction

    // Cubic ease-in-out of one joint, with the fraction in Q0.16.
    function automatic logic [7:0] ease_angle(input logic [7:0] st, input logic [7:0] tg,
                                              input logic [63:0] el, input logic [63:0] dur);
        logic signed [63:0] span;
        logic [63:0] frac;
        logic [63:0] e;
        logic [63:0] g;
        logic signed [63:0] acc;
        span = $signed({56'd0, tg}) - $signed({56'd0, st});
        frac = (el << 16) / dur;
        if (frac < 64'd32768)
            e = (64'd4 * frac * frac * frac) >> 32;
        else
        begin
            g = 64'd65536 - frac;
            e = 64'd65536 - ((64'd4 * g * g * g) >> 32);
        end
        acc = $signed({56'd0, st}) * 64'sd65536 + span * $signed(e);
        if (acc < 0)
            acc = 0;
        return clamp_deg(acc[23:16]);
    endfunction

    // Applies one command word to the shadow state and returns the new pose.
    function automatic out_word_t predict_pose(input in_word_t w);
        out_word_t r;
        logic [7:0] goals[NUM_JOINTS];
        logic [7:0] pos[NUM_JOINTS];
        logic [4:0] mask;
        logic [63:0] d;
        logic [63:0] dur;
        logic [31:0] el;
        goals = '{w.goal_joint1, w.goal_joint2, w.goal_joint3, w.goal_joint4, w.goal_joint5};
        if (w.cmd == CMD_MOVE)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                origin_ms[i]  = w.time_ms;
                origin_ang[i] = now_ang[i];
                goal_ang[i]   = clamp_deg(goals[i]);
            end
        end
        else if (w.cmd == CMD_SET && w.joint_index >= 1 && w.joint_index <= NUM_JOINTS)
        begin
            goal_ang[w.joint_index-1] = clamp_deg(w.single_angle);
            now_ang[w.joint_index-1]  = clamp_deg(w.single_angle);
        end
        mask = '0;
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            if (now_ang[i] != goal_ang[i])
            begin
                d   = (goal_ang[i] > origin_ang[i]) ? goal_ang[i] - origin_ang[i]
                                                    : origin_ang[i] - goal_ang[i];
                dur = d * rate_ms[i];
                el  = w.time_ms - origin_ms[i];
                if ({32'd0, el} >= dur)
                    now_ang[i] = goal_ang[i];
                else
                    now_ang[i] = ease_angle(origin_ang[i], goal_ang[i], {32'd0, el}, dur);
            end
            pos[i] = now_ang[i];
            if (now_ang[i] != goal_ang[i])
                mask[i] = 1'b1;
        end
        r.pos_joint1  = pos[0];
        r.pos_joint2  = pos[1];
        r.pos_joint3  = pos[2];
        r.pos_joint4  = pos[3];
        r.pos_joint5  = pos[4];
        r.moving_mask = mask;
        return r;
    endfunction

    // Writes one rate register, only ever called while the block is idle.
    // The write enable is dropped by the next word that is sent.
    task automatic write_rate(input int idx, input logic [9:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        rate_ms[idx] = val;
    endtask

    // Offers one word, honoring the sender's idle rate, and waits for acceptance.
    // A typed expectation, when given, stands in place of the predictor's.
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t p;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_pose(w);
        if (typed && p != want)
        begin
            $error("typed row disagrees with predictor: exp %h got %h", want, p);
            failures++;
        end
        pose_queue.push_back(typed ? want : p);
    endtask

    // Waits until every expected result has been taken, then idles past the block's worst-case latency.
    task automatic drain();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // The receiver stalls at random; each accepted word is checked field by field.
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $error("result word with nothing expected: %h", out_data);
                    failures++;
                end
                else
                begin
                    exp_w = pose_queue.pop_front();
                    if (out_data.pos_joint1 != exp_w.pos_joint1)
                    begin
                        $error("pos_joint1 exp %0d got %0d", exp_w.pos_joint1, out_data.pos_joint1);
                        failures++;
                    end
                    if (out_data.pos_joint2 != exp_w.pos_joint2)
                    begin
                        $error("pos_joint2 exp %0d got %0d", exp_w.pos_joint2, out_data.pos_joint2);
                        failures++;
                    end
                    if (out_data.pos_joint3 != exp_w.pos_joint3)
                    begin
                        $error("pos_joint3 exp %0d got %0d", exp_w.pos_joint3, out_data.pos_joint3);
                        failures++;
                    end
                    if (out_data.pos_joint4 != exp_w.pos_joint4)
                    begin
                        $error("pos_joint4 exp %0d got %0d", exp_w.pos_joint4, out_data.pos_joint4);
                        failures++;
                    end
                    if (out_data.pos_joint5 != exp_w.pos_joint5)
                    begin
                        $error("pos_joint5 exp %0d got %0d", exp_w.pos_joint5, out_data.pos_joint5);
                        failures++;
                    end
                    if (out_data.moving_mask != exp_w.moving_mask)
                    begin
                        $error("moving_mask exp %h got %h", exp_w.moving_mask,
                               out_data.moving_mask);
                        failures++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        else
            out_ready <= 1'b0;
    end

    // Builds a word from its fields.
    function automatic in_word_t make_word(input logic [1:0] c, input logic [31:0] t,
                                           input logic [2:0] j, input logic [7:0] a,
                                           input logic [39:0] goals);
        in_word_t w;
        w.cmd          = c;
        w.time_ms      = t;
        w.joint_index  = j;
        w.single_angle = a;
        {w.goal_joint1, w.goal_joint2, w.goal_joint3, w.goal_joint4, w.goal_joint5} = goals;
        return w;
    endfunction

    // Angles mostly in range, now and then above it to exercise saturation.
    function automatic logic [7:0] rand_angle();
        return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(180));
    endfunction

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } row_t;

    row_t       rows[$];
    logic [31:0] clock_ms;
    int         phase;
    int         kind;
    in_word_t   w;
    out_word_t  none;

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failures  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        none = '0;
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            rate_ms[i]    = 10'd10;
            goal_ang[i]   = 8'd90;
            origin_ang[i] = 8'd90;
            origin_ms[i]  = '0;
            now_ang[i]    = 8'd90;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Rows with a typed pose are the ones that are obvious: the home
        // pose, instant snaps, ignored joint indexes and an unknown command.
        rows.push_back('{make_word(CMD_TICK, 32'd0, 3'd0, 8'd0, {5{8'd0}}), 1,
                         '{8'd90, 8'd90, 8'd90, 8'd90, 8'd90, 5'd0}});
        rows.push_back('{make_word(CMD_MOVE, 32'd100, 3'd0, 8'd0,
                         {8'd0, 8'd180, 8'd255, 8'd90, 8'd45}), 0, none});
        rows.push_back('{make_word(CMD_TICK, 32'd550, 3'd0, 8'd0, {5{8'd0}}), 0, none});
        rows.push_back('{make_word(CMD_TICK, 32'd1000, 3'd0, 8'd0, {5{8'd0}}), 0, none});
        rows.push_back('{make_word(2'd3, 32'd2000, 3'd7, 8'd255, {5{8'hff}}), 1,
                         '{8'd0, 8'd180, 8'd180, 8'd90, 8'd45, 5'd0}});
        rows.push_back('{make_word(CMD_SET, 32'd2001, 3'd3, 8'd200, {5{8'd0}}), 1,
                         '{8'd0, 8'd180, 8'd180, 8'd90, 8'd45, 5'd0}});
        rows.push_back('{make_word(CMD_SET, 32'd2002, 3'd0, 8'd7, {5{8'd0}}), 1,
                         '{8'd0, 8'd180, 8'd180, 8'd90, 8'd45, 5'd0}});
        rows.push_back('{make_word(CMD_SET, 32'd2003, 3'd6, 8'd7, {5{8'd0}}), 1,
                         '{8'd0, 8'd180, 8'd180, 8'd90, 8'd45, 5'd0}});
        rows.push_back('{make_word(CMD_SET, 32'd2004, 3'd1, 8'd77, {5{8'd0}}), 1,
                         '{8'd77, 8'd180, 8'd180, 8'd90, 8'd45, 5'd0}});
        // A move that wraps the millisecond counter.
        rows.push_back('{make_word(CMD_MOVE, 32'hFFFF_FF00, 3'd0, 8'd0,
                         {8'd180, 8'd0, 8'd0, 8'd180, 8'd0}), 0, none});
        rows.push_back('{make_word(CMD_TICK, 32'h0000_0100, 3'd0, 8'd0, {5{8'd0}}), 0, none});
        rows.push_back('{make_word(CMD_TICK, 32'h0000_0500, 3'd0, 8'd0, {5{8'd0}}), 0, none});
        rows.push_back('{make_word(CMD_TICK, 32'hFFFF_FFFF, 3'd0, 8'd0, {5{8'd0}}), 0, none});
        rows.push_back('{make_word(CMD_SET, 32'hFFFF_FFFF, 3'd5, 8'd180, {5{8'd0}}), 0, none});
        rows.push_back('{make_word(CMD_SET, 32'h0000_1000, 3'd2, 8'd0, {5{8'd0}}), 0, none});
        foreach (rows[k])
            send_word(rows[k].w, rows[k].typed, rows[k].want);
        drain();

        // Zero rate on every joint: any move snaps at once, no division.
        for (int i = 0; i < NUM_JOINTS; i++)
            write_rate(i, 10'd0);
        send_word(make_word(CMD_MOVE, 32'd5000, 3'd0, 8'd0,
                            {8'd10, 8'd20, 8'd30, 8'd40, 8'd50}), 1,
                  '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 5'd0});
        drain();

        // Random phases: each picks fresh rates and an idling mix.
        clock_ms = $urandom;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                case ((phase + i) % 4)
                    0: write_rate(i, 10'd1023);
                    1: write_rate(i, 10'd0);
                    default: write_rate(i, 10'($urandom_range(1, 40)));
                endcase
            end
            for (int n = 0; n < 230; n++)
            begin
                kind = $urandom_range(99);
                if (kind < 12)
                    // Occasional wild timestamp, including backward jumps.
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 600);
                if (kind < 25)
                    w = make_word(CMD_MOVE, clock_ms, 3'($urandom), 8'($urandom),
                                  {rand_angle(), rand_angle(), rand_angle(),
                                   rand_angle(), rand_angle()});
                else if (kind < 37)
                    w = make_word(CMD_SET, clock_ms, 3'($urandom), rand_angle(),
                                  40'({$urandom, $urandom}));
                else if (kind < 40)
                    w = make_word(2'd3, clock_ms, 3'($urandom), 8'($urandom),
                                  40'({$urandom, $urandom}));
                else
                    w = make_word(CMD_TICK, clock_ms, 3'($urandom), 8'($urandom),
                                  40'({$urandom, $urandom}));
                send_word(w, 0, none);
            end
            drain();
        end

        if (failures == 0)
            $display("[multi_joint_eased_motion_profile] OK");
        else
            $display("[multi_joint_eased_motion_profile] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #60000000;
        $display("[multi_joint_eased_motion_profile] ERROR");
        $finish;
    end

endmodule
